// ===== src/rsfc_pkg.sv =====
// Package for the run-packed sprite pixel format converter.
// Holds the word kind codes, walk phases, rewrite modes and shared types.
// It has no dependencies.
package rsfc_pkg;

  localparam int WORD_W      = 16;
  localparam int LINES_W     = 11;
  localparam int MODE_W      = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int MAX_LINES_D = 1024;

  typedef enum logic [2:0] {
    KIND_LINE    = 3'd0,
    KIND_SKIP    = 3'd1,
    KIND_COUNT   = 3'd2,
    KIND_PIXEL   = 3'd3,
    KIND_OUTSIDE = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_LINE  = 2'd0,
    PH_SKIP  = 2'd1,
    PH_COUNT = 2'd2,
    PH_PIXEL = 2'd3
  } phase_t;

  localparam logic [MODE_W-1:0] MODE_TO555     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TO555_TOP = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GREEN_LSB = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SHADOW    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TO565     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CONVERT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT   = 1'd1;

  localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_TO555_TOP;
  localparam logic [LINES_W-1:0] LINES_RESET = '0;

  typedef struct packed {
    kind_t kind;
    logic  done;
  } walk_status_t;

endpackage

// ===== src/rsfc_pixel.sv =====
// Pixel word rewrite for the sprite converter.
// Pure combinational mapping selected by the conversion mode; uses rsfc_pkg.
module rsfc_pixel (
  input  logic [rsfc_pkg::MODE_W-1:0] mode,
  input  logic [rsfc_pkg::WORD_W-1:0] pixel_in,
  output logic [rsfc_pkg::WORD_W-1:0] pixel_out
);

  always_comb begin
    case (mode)
      rsfc_pkg::MODE_TO555: begin
        pixel_out = ((pixel_in & 16'hffc0) >> 1) | (pixel_in & 16'h001f);
      end
      rsfc_pkg::MODE_TO555_TOP: begin
        pixel_out = ((pixel_in & 16'hffc0) >> 1) | (pixel_in & 16'h001f) | 16'h8000;
      end
      rsfc_pkg::MODE_GREEN_LSB: begin
        pixel_out = pixel_in | 16'h0020;
      end
      rsfc_pkg::MODE_SHADOW: begin
        pixel_out = 16'h0000;
      end
      rsfc_pkg::MODE_TO565: begin
        pixel_out = ((pixel_in & 16'h7fe0) << 1) | (pixel_in & 16'h001f);
      end
      default: begin
        pixel_out = pixel_in;
      end
    endcase
  end

endmodule

// ===== src/rsfc_walk.sv =====
// Layout tracker for the sprite converter: line, run and pixel counters.
// Classifies each beat and flags the end of the sprite; uses rsfc_pkg.
module rsfc_walk #(
  parameter int MAX_LINES = rsfc_pkg::MAX_LINES_D
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [rsfc_pkg::WORD_W-1:0]  word,
  input  logic                         start,
  input  logic [rsfc_pkg::LINES_W-1:0] line_count,
  output rsfc_pkg::walk_status_t       status
);

  rsfc_pkg::phase_t             phase_r, phase_nxt;
  logic [rsfc_pkg::LINES_W-1:0] lines_r, lines_nxt;
  logic [rsfc_pkg::WORD_W-1:0]  runs_r, runs_nxt;
  logic [rsfc_pkg::WORD_W-1:0]  pixels_r, pixels_nxt;
  logic [rsfc_pkg::LINES_W-1:0] clamped;
  logic [rsfc_pkg::WORD_W-1:0]  runs_dec;
  logic [rsfc_pkg::LINES_W-1:0] lines_dec;

  always_comb begin
    clamped = (32'(line_count) > MAX_LINES) ? rsfc_pkg::LINES_W'(MAX_LINES) : line_count;
  end

  always_comb begin
    phase_nxt     = phase_r;
    lines_nxt     = lines_r;
    runs_nxt      = runs_r;
    pixels_nxt    = pixels_r;
    status.kind   = rsfc_pkg::KIND_OUTSIDE;
    status.done   = 1'b0;
    runs_dec      = '0;
    lines_dec     = '0;
    if (start) begin
      phase_nxt  = rsfc_pkg::PH_LINE;
      lines_nxt  = clamped;
      runs_nxt   = '0;
      pixels_nxt = '0;
    end
    lines_dec = (lines_nxt != '0) ? lines_nxt - 1'b1 : lines_nxt;
    if (lines_nxt != '0) begin
      case (phase_nxt)
        rsfc_pkg::PH_LINE: begin
          status.kind = rsfc_pkg::KIND_LINE;
          runs_nxt    = word;
          if (word == '0) begin
            lines_nxt   = lines_dec;
            status.done = (lines_dec == '0);
          end else begin
            phase_nxt = rsfc_pkg::PH_SKIP;
          end
        end
        rsfc_pkg::PH_SKIP: begin
          status.kind = rsfc_pkg::KIND_SKIP;
          phase_nxt   = rsfc_pkg::PH_COUNT;
        end
        rsfc_pkg::PH_COUNT, rsfc_pkg::PH_PIXEL: begin
          if (phase_nxt == rsfc_pkg::PH_COUNT) begin
            status.kind = rsfc_pkg::KIND_COUNT;
            pixels_nxt  = word;
          end else begin
            status.kind = rsfc_pkg::KIND_PIXEL;
            pixels_nxt  = (pixels_nxt != '0) ? pixels_nxt - 1'b1 : pixels_nxt;
          end
          if (pixels_nxt == '0) begin
            runs_dec = (runs_nxt != '0) ? runs_nxt - 1'b1 : runs_nxt;
            runs_nxt = runs_dec;
            if (runs_dec == '0) begin
              phase_nxt   = rsfc_pkg::PH_LINE;
              lines_nxt   = lines_dec;
              status.done = (lines_dec == '0);
            end else begin
              phase_nxt = rsfc_pkg::PH_SKIP;
            end
          end else begin
            phase_nxt = rsfc_pkg::PH_PIXEL;
          end
        end
        default: begin
          status.kind = rsfc_pkg::KIND_OUTSIDE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rsfc_pkg::PH_LINE;
      lines_r  <= '0;
      runs_r   <= '0;
      pixels_r <= '0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      lines_r  <= lines_nxt;
      runs_r   <= runs_nxt;
      pixels_r <= pixels_nxt;
    end
  end

endmodule

// ===== src/rle_sprite_pixel_format_converter.sv =====
// Top level of the run-packed sprite pixel format converter.
// Instantiates rsfc_walk and rsfc_pixel; uses rsfc_pkg.
//
// Usage: the sprite stream enters one 16-bit word per beat on the in_
// channel (in_valid/in_stall). in_sprite_start marks the first word of a
// sprite; line_count is sampled on that word. Every input beat yields
// exactly one output beat on the out_ channel (out_valid/out_stall): the
// word, rewritten if it is a pixel, its kind tag and an end-of-sprite flag.
// The datapath is an input register followed by an output register; a
// beat moves from the first to the second when the output register is
// free, and one beat is taken per cycle as long as the receiver keeps
// out_stall low. The layout counters and the bit rewrite both fit between those registers.
// When the receiver stalls, the output register holds its beat and the
// input register fills; in_stall then rises until the output drains.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and are expected only while the block is idle. Synchronous reset clears
// both pipeline registers, returns the walk to outside any sprite, and
// sets convert_mode to 1 and line_count to 0.
module rle_sprite_pixel_format_converter #(
  parameter int MAX_LINES = rsfc_pkg::MAX_LINES_D
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rsfc_pkg::WORD_W-1:0]     in_word_in,
  input  logic                            in_sprite_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rsfc_pkg::WORD_W-1:0]     out_word_out,
  output logic [2:0]                      out_word_kind,
  output logic                            out_sprite_done,
  input  logic                            cfg_we,
  input  logic [rsfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsfc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [rsfc_pkg::MODE_W-1:0]  convert_mode_r;
  logic [rsfc_pkg::LINES_W-1:0] line_count_r;
  logic                         s1_valid_r;
  logic [rsfc_pkg::WORD_W-1:0]  s1_word_r;
  logic                         s1_start_r;
  logic                         out_valid_r;
  logic [rsfc_pkg::WORD_W-1:0]  out_word_r;
  rsfc_pkg::kind_t              out_kind_r;
  logic                         out_done_r;
  logic                         advance;
  logic                         in_fire;
  rsfc_pkg::walk_status_t       status;
  logic [rsfc_pkg::WORD_W-1:0]  pixel_word;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      convert_mode_r <= rsfc_pkg::MODE_RESET;
      line_count_r   <= rsfc_pkg::LINES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rsfc_pkg::CFG_CONVERT_MODE: begin
          convert_mode_r <= cfg_data[rsfc_pkg::MODE_W-1:0];
        end
        rsfc_pkg::CFG_LINE_COUNT: begin
          line_count_r <= cfg_data[rsfc_pkg::LINES_W-1:0];
        end
        default: begin
          line_count_r <= line_count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r  <= in_word_in;
      s1_start_r <= in_sprite_start;
    end
  end

  rsfc_walk #(
    .MAX_LINES(MAX_LINES)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .word      (s1_word_r),
    .start     (s1_start_r),
    .line_count(line_count_r),
    .status    (status)
  );

  rsfc_pixel u_pixel (
    .mode     (convert_mode_r),
    .pixel_in (s1_word_r),
    .pixel_out(pixel_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= (status.kind == rsfc_pkg::KIND_PIXEL) ? pixel_word : s1_word_r;
      out_kind_r <= status.kind;
      out_done_r <= status.done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_word_out    = out_word_r;
  assign out_word_kind   = out_kind_r;
  assign out_sprite_done = out_done_r;

endmodule
